### src/nmea_sentence_framer_core_macros.svh
// ---------------------------------------------------------------------------
// nmea sentence framer assertion macros
// shared concurrent assertion wrappers, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_CORE_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CORE_MACROS_SVH

// property that must hold at every edge outside reset
`define NSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/nsf_pkg.sv
// ---------------------------------------------------------------------------
// nsf_pkg
// types, character codes and event codes of the nmea sentence framer
// ---------------------------------------------------------------------------
package nsf_pkg;

    localparam int MAX_PAYLOAD_DEF = 80;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int FIELD_LAST = 2;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_PAYLOAD   = 4'd1,
        EV_START     = 4'd2,
        EV_OK        = 4'd3,
        EV_PREMATURE = 4'd4,
        EV_MISSING   = 4'd5,
        EV_TOO_LONG  = 4'd6,
        EV_BAD_SUM   = 4'd7,
        EV_BAD_FIELD = 4'd8
    } event_t;

    typedef enum logic [2:0] {
        MODE_SEEK  = 3'b001,
        MODE_BODY  = 3'b010,
        MODE_FIELD = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  payload_count;
        logic [7:0]  xor_acc;
        logic [1:0]  field_char_count;
        logic [11:0] hex_value;
        logic [1:0]  hex_digits_seen;
        logic        hex_stopped;
    } state_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  payload_byte;
        logic [6:0]  sentence_length;
        logic [7:0]  computed_checksum;
        logic [11:0] received_checksum;
    } result_t;

    // bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

### src/nsf_ifs.sv
// ---------------------------------------------------------------------------
// nsf channel interfaces
// valid/ready channels for received characters and framer results
// ---------------------------------------------------------------------------
interface nsf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsf_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  payload_byte;
    logic [6:0]  sentence_length;
    logic [7:0]  computed_checksum;
    logic [11:0] received_checksum;

    modport source (output valid, output event_res, output payload_byte,
                    output sentence_length, output computed_checksum,
                    output received_checksum, input ready);
    modport sink (input valid, input event_res, input payload_byte,
                  input sentence_length, input computed_checksum,
                  input received_checksum, output ready);
endinterface

### src/nmea_sentence_framer_core.sv
// ---------------------------------------------------------------------------
// nmea_sentence_framer_core
// frames nmea 0183 sentences from a character stream and checks the checksum
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  rx       | in  | rx_byte                                   | valid/ready
//  res      | out | event_res, payload_byte, sentence_length, | valid/ready
//           |     | computed_checksum, received_checksum      |
//  cfg      | in  | cfg_wdata (require_checksum)              | cfg_we
//
//  one beat per cycle while res accepts; rx beat goes input reg, then res reg
//  rate set by the combinational parser update between input and result regs
//  reset clears parser state and require_checksum, no clearing pass
//  a stalled res holds its beat; rx keeps accepting while the input reg drains
// ---------------------------------------------------------------------------
`include "nmea_sentence_framer_core_macros.svh"

module nmea_sentence_framer_core #(
    parameter int MAX_PAYLOAD = nsf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    nsf_rx_if.sink          rx,
    nsf_res_if.source       res,
    input  logic            cfg_we,
    input  logic            cfg_wdata
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             res_valid_reg;
    nsf_pkg::result_t res_reg;
    nsf_pkg::state_t  state_reg;
    nsf_pkg::state_t  state_next;
    nsf_pkg::result_t res_next;
    logic             req_sum_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    nsf_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_step (
        .cur              (state_reg),
        .c                (in_byte_reg),
        .require_checksum (req_sum_reg),
        .nxt              (state_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            req_sum_reg   <= 1'b0;
            state_reg     <= '{mode: nsf_pkg::MODE_SEEK, default: '0};
        end else begin
            if (cfg_we) begin
                req_sum_reg <= cfg_wdata;
            end
            if (rx.ready) begin
                in_valid_reg <= rx.valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
            end else if (res.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid) begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.event_res         = res_reg.event_res;
    assign res.payload_byte      = res_reg.payload_byte;
    assign res.sentence_length   = res_reg.sentence_length;
    assign res.computed_checksum = res_reg.computed_checksum;
    assign res.received_checksum = res_reg.received_checksum;

    `NSF_ASSERT(a_count_bound, state_reg.payload_count <= 7'(MAX_PAYLOAD),
        "payload count above maximum")
    `NSF_ASSERT(a_pbyte_only_payload,
        !res_valid_reg || res_reg.event_res == nsf_pkg::EV_PAYLOAD || res_reg.payload_byte == 8'd0,
        "payload byte set on non-payload beat")
    `NSF_ASSERT(a_rsum_only_field,
        !res_valid_reg || res_reg.event_res == nsf_pkg::EV_OK
            || res_reg.event_res == nsf_pkg::EV_BAD_SUM || res_reg.received_checksum == 12'd0,
        "received checksum set on wrong event")
    `NSF_ASSERT_NEXT(a_dollar_restarts, advance && in_byte_reg == nsf_pkg::CH_DOLLAR,
        state_reg.mode == nsf_pkg::MODE_BODY && state_reg.payload_count == 7'd0,
        "start character did not restart sentence")
    `NSF_ASSERT_NEXT(a_stall_holds_result, res_valid_reg && !res.ready,
        res_valid_reg && $stable(res_reg),
        "stalled result changed")

endmodule

### src/nsf_step.sv
// ---------------------------------------------------------------------------
// nsf_step
// per-character framing update: next parser state and the result of one beat
// ---------------------------------------------------------------------------
module nsf_step #(
    parameter int MAX_PAYLOAD = nsf_pkg::MAX_PAYLOAD_DEF
) (
    input  nsf_pkg::state_t  cur,
    input  logic [7:0]       c,
    input  logic             require_checksum,
    output nsf_pkg::state_t  nxt,
    output nsf_pkg::result_t res
);

    logic [4:0] nib;
    logic       eol;
    logic [2:0] n;

    assign nib = nsf_pkg::hex_nibble(c);
    assign eol = (c == nsf_pkg::CH_LF) || (c == nsf_pkg::CH_CR);
    assign n   = {1'b0, cur.field_char_count} + 3'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.event_res = nsf_pkg::EV_NONE;
        if (c == nsf_pkg::CH_DOLLAR) begin
            res.event_res = (cur.mode == nsf_pkg::MODE_BODY || cur.mode == nsf_pkg::MODE_FIELD)
                          ? nsf_pkg::EV_PREMATURE : nsf_pkg::EV_START;
            nxt.mode          = nsf_pkg::MODE_BODY;
            nxt.payload_count = 7'd0;
            nxt.xor_acc       = 8'd0;
        end else begin
            case (cur.mode)
                nsf_pkg::MODE_BODY:
                begin
                    if (c == nsf_pkg::CH_STAR) begin
                        nxt.mode             = nsf_pkg::MODE_FIELD;
                        nxt.field_char_count = 2'd0;
                        nxt.hex_value        = 12'd0;
                        nxt.hex_digits_seen  = 2'd0;
                        nxt.hex_stopped      = 1'b0;
                    end else if (eol) begin
                        res.event_res = require_checksum ? nsf_pkg::EV_MISSING
                                                         : nsf_pkg::EV_OK;
                        nxt.mode = nsf_pkg::MODE_SEEK;
                    end else if (cur.payload_count >= 7'(MAX_PAYLOAD)) begin
                        res.event_res = nsf_pkg::EV_TOO_LONG;
                        nxt.mode      = nsf_pkg::MODE_SEEK;
                    end else begin
                        nxt.payload_count = cur.payload_count + 7'd1;
                        nxt.xor_acc       = cur.xor_acc ^ c;
                        res.event_res     = nsf_pkg::EV_PAYLOAD;
                        res.payload_byte  = c;
                    end
                end
                nsf_pkg::MODE_FIELD:
                begin
                    if (!cur.hex_stopped && nib[4]) begin
                        nxt.hex_value       = {cur.hex_value[7:0], nib[3:0]};
                        nxt.hex_digits_seen = cur.hex_digits_seen + 2'd1;
                    end else begin
                        nxt.hex_stopped = 1'b1;
                    end
                    // field closes on its third character or at end of line
                    if (n > 3'(nsf_pkg::FIELD_LAST) || eol) begin
                        if (nxt.hex_digits_seen == 2'd0) begin
                            res.event_res = nsf_pkg::EV_BAD_FIELD;
                        end else begin
                            res.event_res = (nxt.hex_value == {4'h0, cur.xor_acc})
                                          ? nsf_pkg::EV_OK : nsf_pkg::EV_BAD_SUM;
                            res.received_checksum = nxt.hex_value;
                        end
                        nxt.mode             = nsf_pkg::MODE_SEEK;
                        nxt.field_char_count = 2'd0;
                    end else begin
                        nxt.field_char_count = n[1:0];
                    end
                end
                default:
                begin
                    nxt.mode = cur.mode;
                end
            endcase
        end
        res.sentence_length   = nxt.payload_count;
        res.computed_checksum = nxt.xor_acc;
    end

endmodule

### tb/sv/nmea_sentence_framer_core_tb.sv
// ---------------------------------------------------------------------------
// nmea_sentence_framer_core_tb
// drives character streams into the framer and checks every result beat
// against a cycle-free model of the parser, across both checksum settings
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module nmea_sentence_framer_core_tb;

    localparam int MAX_LEN = nsf_pkg::MAX_PAYLOAD_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 460;
    localparam int HOLDOFF_AT = 400;
    localparam int HOLDOFF_CYCLES = 150;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    nsf_rx_if  rx_ch ();
    nsf_res_if res_ch ();

    nmea_sentence_framer_core #(
        .MAX_PAYLOAD (MAX_LEN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // parser model state
    nsf_pkg::mode_t fr_mode;
    logic [6:0]     fr_count;
    logic [7:0]     fr_xor;
    logic [1:0]     fr_field_n;
    logic [11:0]    fr_hex;
    logic [1:0]     fr_digits;
    logic           fr_stopped;
    logic           fr_require;

    logic [7:0]       rx_pending[$];
    nsf_pkg::result_t expected_frames[$];
    nsf_pkg::result_t frame_want;

    int fail_count = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_run = 0;
    int holdoff_left = 0;
    bit holdoff_done = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic nsf_pkg::result_t frame_step(input logic [7:0] c);
        nsf_pkg::result_t r;
        logic             eol;
        logic             is_hex;
        logic [3:0]       nib;
        int               n;
        r = '0;
        r.event_res = nsf_pkg::EV_NONE;
        eol = (c == nsf_pkg::CH_LF) || (c == nsf_pkg::CH_CR);
        if (c == nsf_pkg::CH_DOLLAR) begin
            r.event_res = (fr_mode == nsf_pkg::MODE_BODY || fr_mode == nsf_pkg::MODE_FIELD)
                        ? nsf_pkg::EV_PREMATURE : nsf_pkg::EV_START;
            fr_mode = nsf_pkg::MODE_BODY;
            fr_count = '0;
            fr_xor = '0;
        end else if (fr_mode == nsf_pkg::MODE_BODY) begin
            if (c == nsf_pkg::CH_STAR) begin
                fr_mode = nsf_pkg::MODE_FIELD;
                fr_field_n = '0;
                fr_hex = '0;
                fr_digits = '0;
                fr_stopped = 1'b0;
            end else if (eol) begin
                r.event_res = fr_require ? nsf_pkg::EV_MISSING : nsf_pkg::EV_OK;
                fr_mode = nsf_pkg::MODE_SEEK;
            end else if (fr_count >= MAX_LEN) begin
                // byte is dropped, count and xor stay until the next start
                r.event_res = nsf_pkg::EV_TOO_LONG;
                fr_mode = nsf_pkg::MODE_SEEK;
            end else begin
                fr_count = fr_count + 7'd1;
                fr_xor = fr_xor ^ c;
                r.event_res = nsf_pkg::EV_PAYLOAD;
                r.payload_byte = c;
            end
        end else if (fr_mode == nsf_pkg::MODE_FIELD) begin
            is_hex = 1'b1;
            nib = '0;
            if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
                nib = 4'(c - CH_ZERO);
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
                nib = 4'(c - CH_UPPER_A + 8'd10);
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
                nib = 4'(c - CH_LOWER_A + 8'd10);
            end else begin
                is_hex = 1'b0;
            end
            n = int'(fr_field_n) + 1;
            // first non-hex character freezes the collected value
            if (!fr_stopped && is_hex) begin
                fr_hex = {fr_hex[7:0], nib};
                fr_digits = fr_digits + 2'd1;
            end else begin
                fr_stopped = 1'b1;
            end
            if (n > nsf_pkg::FIELD_LAST || eol) begin
                if (fr_digits == 2'd0) begin
                    r.event_res = nsf_pkg::EV_BAD_FIELD;
                end else begin
                    r.event_res = (fr_hex == {4'd0, fr_xor}) ? nsf_pkg::EV_OK
                                                             : nsf_pkg::EV_BAD_SUM;
                    r.received_checksum = fr_hex;
                end
                fr_mode = nsf_pkg::MODE_SEEK;
                fr_field_n = '0;
            end else begin
                fr_field_n = 2'(n);
            end
        end
        r.sentence_length = fr_count;
        r.computed_checksum = fr_xor;
        return r;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return CH_ZERO + 8'(nib);
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib - 4'd10);
    endfunction

    function automatic logic [7:0] eol_char();
        return ($urandom_range(0, 1) != 0) ? nsf_pkg::CH_CR : nsf_pkg::CH_LF;
    endfunction

    function automatic logic [7:0] payload_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == nsf_pkg::CH_DOLLAR || b == nsf_pkg::CH_STAR
               || b == nsf_pkg::CH_CR || b == nsf_pkg::CH_LF) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] field_char();
        case ($urandom_range(0, 2))
            0: return hex_ascii(4'($urandom_range(0, 15)), $urandom_range(0, 1) != 0);
            1: return 8'($urandom_range(0, 255));
            default: return ($urandom_range(0, 1) != 0) ? 8'h2C : 8'h47;
        endcase
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            rx_pending.push_back(s[i]);
        end
    endtask

    task automatic push_hex_pair(input logic [7:0] v, input bit upper);
        rx_pending.push_back(hex_ascii(v[7:4], upper));
        rx_pending.push_back(hex_ascii(v[3:0], upper));
    endtask

    task automatic add_sentence();
        int         len;
        int         kind;
        int         cut;
        logic [7:0] sum;
        logic [7:0] b;
        bit         upper;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 15))
            0: len = $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
            1: len = 0;
            default: len = $urandom_range(1, 24);
        endcase
        kind = $urandom_range(0, 9);
        cut = (kind == 8) ? $urandom_range(0, len) : -1;
        upper = ($urandom_range(0, 1) != 0);
        rx_pending.push_back(nsf_pkg::CH_DOLLAR);
        sum = '0;
        for (int i = 0; i < len; i++) begin
            // restart in the middle of a sentence
            if (i == cut) begin
                rx_pending.push_back(nsf_pkg::CH_DOLLAR);
                sum = '0;
            end
            b = payload_char();
            sum = sum ^ b;
            rx_pending.push_back(b);
        end
        case (kind)
            0, 1, 2, 3, 8: begin
                rx_pending.push_back(nsf_pkg::CH_STAR);
                push_hex_pair(sum, upper);
                rx_pending.push_back(nsf_pkg::CH_CR);
                if ($urandom_range(0, 1) != 0) begin
                    rx_pending.push_back(nsf_pkg::CH_LF);
                end
            end
            4: begin
                rx_pending.push_back(nsf_pkg::CH_STAR);
                push_hex_pair(sum ^ 8'($urandom_range(1, 255)), upper);
                rx_pending.push_back(eol_char());
            end
            5: begin
                rx_pending.push_back(nsf_pkg::CH_STAR);
                repeat ($urandom_range(0, 3)) rx_pending.push_back(field_char());
                rx_pending.push_back(eol_char());
            end
            6: rx_pending.push_back(eol_char());
            7: begin
                // three-digit field, ends on its last character
                rx_pending.push_back(nsf_pkg::CH_STAR);
                if ($urandom_range(0, 1) != 0) begin
                    rx_pending.push_back(CH_ZERO);
                    push_hex_pair(sum, upper);
                end else begin
                    repeat (3) begin
                        rx_pending.push_back(hex_ascii(4'($urandom_range(0, 15)), upper));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic write_require(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        fr_require = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sampled away from the rising edge so driver and monitor updates have settled
    task automatic drain();
        while (rx_pending.size() != 0 || rx_ch.valid || expected_frames.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= '0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                expected_frames.push_back(frame_step(rx_ch.rx_byte));
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_ch.valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    rx_ch.valid <= 1'b1;
                    rx_ch.rx_byte <= rx_pending.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off to back up the input
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            res_ch.ready <= 1'b0;
        end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(8, 64);
            end
            stall_run--;
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 1) != 0);
                2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (expected_frames.size() == 0) begin
                $error("result beat with no expected frame pending");
                fail_count++;
            end else begin
                frame_want = expected_frames.pop_front();
                check_field("event_res", 12'(frame_want.event_res), 12'(res_ch.event_res));
                check_field("payload_byte", 12'(frame_want.payload_byte),
                            12'(res_ch.payload_byte));
                check_field("sentence_length", 12'(frame_want.sentence_length),
                            12'(res_ch.sentence_length));
                check_field("computed_checksum", 12'(frame_want.computed_checksum),
                            12'(res_ch.computed_checksum));
                check_field("received_checksum", frame_want.received_checksum,
                            res_ch.received_checksum);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int target;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        fr_mode = nsf_pkg::MODE_SEEK;
        fr_count = '0;
        fr_xor = '0;
        fr_field_n = '0;
        fr_hex = '0;
        fr_digits = '0;
        fr_stopped = 1'b0;
        fr_require = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: noise while seeking, field ok, no field, bad sum,
        // restart mid-sentence, empty field ending on eol
        write_require(1'b0);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        push_text("$AB*03\r");
        rx_pending.push_back(nsf_pkg::CH_DOLLAR);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(nsf_pkg::CH_CR);
        push_text("$x*7\n");
        push_text("$b$*\r");
        drain();
        write_require(1'b1);
        push_text("$q\n");
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_require(phase[0]);
            target = rx_pending.size() + PHASE_ITEMS;
            while (rx_pending.size() < target) begin
                add_sentence();
            end
            drain();
        end

        repeat (6) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### nmea_sentence_framer_core.f
+incdir+src
src/nsf_pkg.sv
src/nsf_ifs.sv
src/nsf_step.sv
src/nmea_sentence_framer_core.sv
tb/sv/nmea_sentence_framer_core_tb.sv
